// File: hdl/ttt_pkg.sv
`default_nettype none

package ttt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [31:0] LIMIT_RESET = 32'd5000;
    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

    typedef logic [IDX_W-1:0] slot_idx_t;

    typedef enum logic [1:0] {
        FN_START = 2'd0,
        FN_STOP  = 2'd1,
        FN_CHECK = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_STARTED   = 3'd0,
        ST_FULL      = 3'd1,
        ST_STOPPED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_CHECK     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        SQ_IDLE  = 3'b001,
        SQ_SCAN  = 3'b010,
        SQ_FLUSH = 3'b100
    } seq_state_t;

    // read view of one slot
    typedef struct packed {
        logic        valid;
        logic [31:0] task_id;
        logic [31:0] start_ms;
        logic [31:0] limit_ms;
    } slot_rd_t;

    // write of one slot, marks it valid
    typedef struct packed {
        logic        en;
        slot_idx_t   idx;
        logic [31:0] task_id;
        logic [31:0] start_ms;
        logic [31:0] limit_ms;
    } slot_wr_t;

    // removal of one slot
    typedef struct packed {
        logic      en;
        slot_idx_t idx;
    } slot_clr_t;

endpackage

`default_nettype wire

// File: hdl/ttt_slot_store.sv
`default_nettype none

module ttt_slot_store (
    input  wire                 clk,
    input  wire                 rst_n,
    input  ttt_pkg::slot_idx_t  rd_idx,
    output ttt_pkg::slot_rd_t   rd,
    input  ttt_pkg::slot_wr_t   wr,
    input  ttt_pkg::slot_clr_t  clr
);
    import ttt_pkg::*;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [31:0]            id_reg    [TABLE_DEPTH];
    logic [31:0]            start_reg [TABLE_DEPTH];
    logic [31:0]            limit_reg [TABLE_DEPTH];

    // valid bits, cleared at once on reset
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            if (wr.en) begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (clr.en) begin
                valid_reg[clr.idx] <= 1'b0;
            end
        end
    end

    // slot contents
    always_ff @(posedge clk) begin
        if (wr.en) begin
            id_reg[wr.idx]    <= wr.task_id;
            start_reg[wr.idx] <= wr.start_ms;
            limit_reg[wr.idx] <= wr.limit_ms;
        end
    end

    assign rd.valid    = valid_reg[rd_idx];
    assign rd.task_id  = id_reg[rd_idx];
    assign rd.start_ms = start_reg[rd_idx];
    assign rd.limit_ms = limit_reg[rd_idx];

endmodule

`default_nettype wire

// File: hdl/task_timeout_table_core.sv
`default_nettype none

// Task timeout table. A transaction is taken when start is high and busy is
// low; every accepted start, stop or check item walks all table slots, one
// slot per cycle through a single id comparator and elapsed-time subtract and
// compare, so one item keeps busy high through the walk of all TABLE_DEPTH
// slots (SQ_SCAN) and then the commit state (SQ_FLUSH). Results come out as
// one-cycle pulses on result_valid with their fields alongside, and the
// receiver cannot stall them: capture every pulse. Start, stop and
// check-with-nothing-expired give one result; a check gives one result per
// expired entry (in slot order, at most MAX_RESULTS), with last marking the
// final one, and the final result strobes in the same cycle that busy drops.
// func code 3 is taken and dropped with no result and no busy time. The limit
// register is written through cfg_valid/cfg_ready while the block is idle and
// no command is offered on start.
module task_timeout_table_core (
    input  wire          clk,
    input  wire          rst_n,
    // command channel
    input  wire          start,
    output logic         busy,
    input  wire  [1:0]   func,
    input  wire  [31:0]  task_id,
    input  wire  [31:0]  time_now_ms,
    // limit register write
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [31:0]  cfg_data,
    // results
    output logic         result_valid,
    output logic [2:0]   status,
    output logic         expired,
    output logic [31:0]  expired_id,
    output logic [31:0]  elapsed_ms,
    output logic [31:0]  timeout_total,
    output logic         last
);
    import ttt_pkg::*;

    // sequencer and item registers
    seq_state_t  state_reg, state_next;
    func_t       func_reg, func_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] now_reg, now_next;
    slot_idx_t   idx_reg, idx_next;

    // lookup results of the walk
    logic        hit_found_reg, hit_found_next;
    slot_idx_t   hit_idx_reg, hit_idx_next;
    logic        free_found_reg, free_found_next;
    slot_idx_t   free_idx_reg, free_idx_next;

    // expired entry held back until we know whether it is the final one
    logic             pend_reg, pend_next;
    logic [31:0]      pend_id_reg, pend_id_next;
    logic [31:0]      pend_elapsed_reg, pend_elapsed_next;
    logic [31:0]      pend_total_reg, pend_total_next;
    logic [CNT_W-1:0] n_reg, n_next;

    logic [31:0] limit_reg, limit_next;
    logic [31:0] count_reg, count_next;

    // result register
    logic        res_valid_next;
    logic [2:0]  status_next;
    logic        expired_next;
    logic [31:0] expired_id_next;
    logic [31:0] elapsed_next;
    logic [31:0] total_next;
    logic        last_next;

    slot_rd_t  slot_rd;
    slot_wr_t  slot_wr;
    slot_clr_t slot_clr;

    // shared compare unit on the slot under the walk index
    logic        id_match;
    logic [31:0] slot_elapsed;
    logic        slot_over;
    logic        idx_last;

    ttt_slot_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (idx_reg),
        .rd     (slot_rd),
        .wr     (slot_wr),
        .clr    (slot_clr)
    );

    assign id_match     = slot_rd.valid && (slot_rd.task_id == id_reg);
    assign slot_elapsed = now_reg - slot_rd.start_ms;
    assign slot_over    = slot_rd.valid && (slot_elapsed > slot_rd.limit_ms);
    assign idx_last     = (idx_reg == IDX_W'(TABLE_DEPTH - 1));

    assign busy      = (state_reg != SQ_IDLE);
    // a command offered in the same cycle goes first
    assign cfg_ready = !busy && !start;

    always_comb begin
        state_next        = state_reg;
        func_next         = func_reg;
        id_next           = id_reg;
        now_next          = now_reg;
        idx_next          = idx_reg;
        hit_found_next    = hit_found_reg;
        hit_idx_next      = hit_idx_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        pend_next         = pend_reg;
        pend_id_next      = pend_id_reg;
        pend_elapsed_next = pend_elapsed_reg;
        pend_total_next   = pend_total_reg;
        n_next            = n_reg;
        limit_next        = limit_reg;
        count_next        = count_reg;

        res_valid_next  = 1'b0;
        status_next     = status;
        expired_next    = expired;
        expired_id_next = expired_id;
        elapsed_next    = elapsed_ms;
        total_next      = timeout_total;
        last_next       = last;

        slot_wr          = '0;
        slot_wr.idx      = hit_found_reg ? hit_idx_reg : free_idx_reg;
        slot_wr.task_id  = id_reg;
        slot_wr.start_ms = now_reg;
        slot_wr.limit_ms = limit_reg;
        slot_clr         = '0;

        if (cfg_valid && cfg_ready) begin
            limit_next = cfg_data;
        end

        unique case (state_reg)
            SQ_IDLE: begin
                if (start && func_t'(func) != FN_NONE) begin
                    state_next      = SQ_SCAN;
                    func_next       = func_t'(func);
                    id_next         = task_id;
                    now_next        = time_now_ms;
                    idx_next        = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    pend_next       = 1'b0;
                    n_next          = '0;
                end
            end

            SQ_SCAN: begin
                if (func_reg == FN_CHECK) begin
                    if (slot_over && (n_reg < CNT_W'(MAX_RESULTS))) begin
                        slot_clr.en  = 1'b1;
                        slot_clr.idx = idx_reg;
                        if (count_reg != COUNT_MAX) begin
                            count_next = count_reg + 32'd1;
                        end
                        // the earlier expired entry is now known not to be final
                        if (pend_reg) begin
                            res_valid_next  = 1'b1;
                            status_next     = ST_CHECK;
                            expired_next    = 1'b1;
                            expired_id_next = pend_id_reg;
                            elapsed_next    = pend_elapsed_reg;
                            total_next      = pend_total_reg;
                            last_next       = 1'b0;
                        end
                        pend_next         = 1'b1;
                        pend_id_next      = slot_rd.task_id;
                        pend_elapsed_next = slot_elapsed;
                        pend_total_next   = count_next;
                        n_next            = n_reg + CNT_W'(1);
                    end
                end
                else begin
                    if (id_match && !hit_found_reg) begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = idx_reg;
                    end
                    if (!slot_rd.valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                end
                if (idx_last) begin
                    state_next = SQ_FLUSH;
                end
                else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            SQ_FLUSH: begin
                state_next      = SQ_IDLE;
                res_valid_next  = 1'b1;
                expired_next    = 1'b0;
                expired_id_next = '0;
                elapsed_next    = '0;
                total_next      = count_reg;
                last_next       = 1'b1;
                unique case (func_reg)
                    FN_START: begin
                        if (hit_found_reg || free_found_reg) begin
                            slot_wr.en  = 1'b1;
                            status_next = ST_STARTED;
                        end
                        else begin
                            status_next = ST_FULL;
                        end
                    end
                    FN_STOP: begin
                        if (hit_found_reg) begin
                            slot_clr.en  = 1'b1;
                            slot_clr.idx = hit_idx_reg;
                            status_next  = ST_STOPPED;
                        end
                        else begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        // check: final expired entry, or the empty report
                        status_next = ST_CHECK;
                        if (pend_reg) begin
                            expired_next    = 1'b1;
                            expired_id_next = pend_id_reg;
                            elapsed_next    = pend_elapsed_reg;
                            total_next      = pend_total_reg;
                        end
                    end
                endcase
            end

            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= SQ_IDLE;
            limit_reg    <= LIMIT_RESET;
            count_reg    <= '0;
            result_valid <= 1'b0;
        end
        else begin
            state_reg    <= state_next;
            limit_reg    <= limit_next;
            count_reg    <= count_next;
            result_valid <= res_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk) begin
        func_reg         <= func_next;
        id_reg           <= id_next;
        now_reg          <= now_next;
        idx_reg          <= idx_next;
        hit_found_reg    <= hit_found_next;
        hit_idx_reg      <= hit_idx_next;
        free_found_reg   <= free_found_next;
        free_idx_reg     <= free_idx_next;
        pend_reg         <= pend_next;
        pend_id_reg      <= pend_id_next;
        pend_elapsed_reg <= pend_elapsed_next;
        pend_total_reg   <= pend_total_next;
        n_reg            <= n_next;
        status           <= status_next;
        expired          <= expired_next;
        expired_id       <= expired_id_next;
        elapsed_ms       <= elapsed_next;
        timeout_total    <= total_next;
        last             <= last_next;
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ttt_pkg::*;

    // run limit for about 430 items, with their busy time and idle gaps
    localparam int CYCLE_LIMIT = 400000;
    // extra idle time after the last result
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int POOL_SIZE = 20;
    localparam int RANDOM_PER_PHASE = 67;
    localparam int MAX_PRINTED = 200;

    // one expected result of the table
    typedef struct {
        status_t     status;
        logic        expired;
        logic [31:0] exp_id;
        logic [31:0] elapsed;
        logic [31:0] total;
        logic        last;
    } timeout_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [31:0] task_id;
    logic [31:0] time_now_ms;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        result_valid;
    logic [2:0]  status;
    logic        expired;
    logic [31:0] expired_id;
    logic [31:0] elapsed_ms;
    logic [31:0] timeout_total;
    logic        last;

    // shadow copy of the table, updated when a transaction is taken
    logic        shadow_valid [TABLE_DEPTH];
    logic [31:0] shadow_id    [TABLE_DEPTH];
    logic [31:0] shadow_start [TABLE_DEPTH];
    logic [31:0] shadow_limit [TABLE_DEPTH];
    logic [31:0] shadow_count;
    logic [31:0] limit_setting;

    timeout_result_t awaited_results [$];

    int          error_count;
    int          cycle_count;
    logic        no_idle;
    logic [31:0] clock_ms;
    logic [31:0] id_pool [POOL_SIZE];
    string       field_name [6] = '{"status", "expired", "expired_id", "elapsed_ms",
                                    "timeout_total", "last"};

    task_timeout_table_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .task_id       (task_id),
        .time_now_ms   (time_now_ms),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .status        (status),
        .expired       (expired),
        .expired_id    (expired_id),
        .elapsed_ms    (elapsed_ms),
        .timeout_total (timeout_total),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_error(string msg);
        if (error_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void push_result(status_t st, logic hit, logic [31:0] id,
                                        logic [31:0] age, logic fin);
        timeout_result_t r;
        r.status  = st;
        r.expired = hit;
        r.exp_id  = id;
        r.elapsed = age;
        r.total   = shadow_count;
        r.last    = fin;
        awaited_results.insert(awaited_results.size(), r);
    endfunction

    // applies one taken command to the shadow table and queues its results
    function automatic void apply_command(func_t fn, logic [31:0] id, logic [31:0] now);
        int          hit;
        int          free_slot;
        int          n;
        logic [31:0] age;
        hit = -1;
        free_slot = -1;
        n = 0;
        case (fn)
            FN_START:
            begin
                // first matching id wins, else the lowest free slot
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (shadow_valid[i])
                    begin
                        if (hit < 0 && shadow_id[i] == id)
                            hit = i;
                    end
                    else if (free_slot < 0)
                        free_slot = i;
                end
                if (hit < 0)
                    hit = free_slot;
                if (hit < 0)
                    push_result(ST_FULL, 1'b0, '0, '0, 1'b1);
                else
                begin
                    shadow_valid[hit] = 1'b1;
                    shadow_id[hit]    = id;
                    shadow_start[hit] = now;
                    shadow_limit[hit] = limit_setting;
                    push_result(ST_STARTED, 1'b0, '0, '0, 1'b1);
                end
            end
            FN_STOP:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (hit < 0 && shadow_valid[i] && shadow_id[i] == id)
                        hit = i;
                if (hit >= 0)
                begin
                    shadow_valid[hit] = 1'b0;
                    push_result(ST_STOPPED, 1'b0, '0, '0, 1'b1);
                end
                else
                    push_result(ST_NOT_FOUND, 1'b0, '0, '0, 1'b1);
            end
            FN_CHECK:
            begin
                for (int i = 0; i < TABLE_DEPTH && n < MAX_RESULTS; i++)
                begin
                    if (shadow_valid[i])
                    begin
                        // elapsed wraps modulo 2^32, strictly above the limit expires
                        age = now - shadow_start[i];
                        if (age > shadow_limit[i])
                        begin
                            shadow_valid[i] = 1'b0;
                            if (shadow_count != COUNT_MAX)
                                shadow_count = shadow_count + 1;
                            push_result(ST_CHECK, 1'b1, shadow_id[i], age, 1'b0);
                            n++;
                        end
                    end
                end
                if (n == 0)
                    push_result(ST_CHECK, 1'b0, '0, '0, 1'b1);
                else
                    awaited_results[awaited_results.size() - 1].last = 1'b1;
            end
            default:
                ; // unused code, taken and dropped
        endcase
    endfunction

    // result checker, results cannot be stalled so every strobe is taken
    always @(posedge clk)
    begin : check_results
        timeout_result_t want;
        logic [31:0]     got_f  [6];
        logic [31:0]     want_f [6];
        if (rst_n && result_valid)
        begin
            if (awaited_results.size() == 0)
                report_error($sformatf("unexpected result status %0d id %h elapsed %h",
                                       status, expired_id, elapsed_ms));
            else
            begin
                want = awaited_results.pop_front();
                got_f  = '{32'(status), 32'(expired), expired_id, elapsed_ms,
                           timeout_total, 32'(last)};
                want_f = '{32'(want.status), 32'(want.expired), want.exp_id,
                           want.elapsed, want.total, 32'(want.last)};
                for (int f = 0; f < 6; f++)
                    if (got_f[f] !== want_f[f])
                        report_error($sformatf("%s got %h want %h", field_name[f],
                                               got_f[f], want_f[f]));
            end
        end
    end

    // one command transaction: optional gap, raise start, hold until taken
    task automatic send_item(func_t fn, logic [31:0] id, logic [31:0] now);
        if (!no_idle && $urandom_range(99) < 21)
            repeat ($urandom_range(1, 24)) @(negedge clk);
        @(negedge clk);
        start       <= 1'b1;
        func        <= fn;
        task_id     <= id;
        time_now_ms <= now;
        do
            @(posedge clk);
        while (busy);
        apply_command(fn, id, now);
        @(negedge clk);
        start <= 1'b0;
    endtask

    // wait for every awaited result, then idle a little longer
    task automatic drain_results();
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // limit register write, only with the block idle
    task automatic load_limit(logic [31:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        limit_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // fill, full table, refresh, exact limit, wrap, all sixteen expiring, stop paths
    task automatic test_table_ops();
        logic [31:0] t0;
        t0 = 32'hFFFF_FF00;
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(FN_START, (i == 0) ? 32'h0 :
                                (i == TABLE_DEPTH - 1) ? 32'hFFFF_FFFF : $urandom, t0);
        send_item(FN_START, 32'h1357_9BDF, t0);       // table full, dropped
        send_item(FN_START, 32'h0, t0 + 1);            // refresh a matching id while full
        send_item(FN_NONE, $urandom, $urandom);        // unused code, no result
        send_item(FN_CHECK, $urandom, t0 + 1);         // nothing expired yet
        send_item(FN_CHECK, $urandom, t0 + 5000);      // elapsed equal to limit, nothing
        send_item(FN_CHECK, $urandom, t0 + 5002);      // wraps past zero, all expire
        send_item(FN_STOP, 32'hFFFF_FFFF, t0);         // id absent
        send_item(FN_START, 32'hFFFF_FFFF, t0);
        send_item(FN_STOP, 32'hFFFF_FFFF, t0);
    endtask

    // limit register at both ends
    task automatic test_limit_extremes();
        load_limit(32'h0);
        send_item(FN_START, 32'hA5A5_0001, 32'h8000_0000);
        send_item(FN_CHECK, $urandom, 32'h8000_0000);  // elapsed zero never expires
        send_item(FN_CHECK, $urandom, 32'h8000_0001);
        load_limit(32'hFFFF_FFFF);
        send_item(FN_START, 32'h5A5A_0002, 32'h1234_5678);
        send_item(FN_CHECK, $urandom, 32'h1234_5677);  // largest elapsed, still no timeout
        send_item(FN_STOP, 32'h5A5A_0002, 32'h1234_5678);
    endtask

    // mostly ids from a small pool so starts refresh and stops hit
    task automatic run_random_items(int count);
        int          pick;
        func_t       fn;
        logic [31:0] id;
        for (int k = 0; k < count; k++)
        begin
            no_idle = (k >= 20 && k < 45);
            pick = $urandom_range(99);
            if ($urandom_range(9) == 0)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, 1500);
            id = ($urandom_range(4) == 0) ? $urandom : id_pool[$urandom_range(POOL_SIZE - 1)];
            if (pick < 40)
                fn = FN_START;
            else if (pick < 62)
                fn = FN_STOP;
            else if (pick < 95)
                fn = FN_CHECK;
            else
                fn = FN_NONE;
            send_item(fn, id, clock_ms);
            // hold the sender off until the table has answered everything
            if (k % 50 == 49)
                drain_results();
        end
        no_idle = 1'b0;
    endtask

    // random traffic under a sequence of limit settings
    task automatic test_random_phases();
        logic [31:0] limits [6];
        limits = '{32'd1000, 32'd0, $urandom, 32'hFFFF_FFFF,
                   32'($urandom_range(1, 3000)), LIMIT_RESET};
        for (int i = 0; i < POOL_SIZE; i++)
            id_pool[i] = $urandom;
        id_pool[0] = 32'h0;
        id_pool[1] = 32'hFFFF_FFFF;
        clock_ms = $urandom;
        foreach (limits[p])
        begin
            load_limit(limits[p]);
            run_random_items(RANDOM_PER_PHASE);
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        func        <= FN_START;
        task_id     <= '0;
        time_now_ms <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        error_count = 0;
        cycle_count = 0;
        no_idle     = 1'b0;
        // shadow state after reset
        limit_setting = LIMIT_RESET;
        shadow_count  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_id[i]    = '0;
            shadow_start[i] = '0;
            shadow_limit[i] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_table_ops();
        test_limit_extremes();
        test_random_phases();
        drain_results();

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
